// ----- hdl/cba_pkg.sv -----
// Shared types and constants of the confidence bitrate adjuster.
`timescale 1ns / 1ps
`default_nettype none
package cba_pkg;

	localparam int KBPS_W  = 20;
	localparam int FRAME_W = 31;
	localparam int ROWIX_W = 10;
	localparam int TIERIX_W = 3;
	localparam int CONFIN_W = 16;
	localparam int THR_W   = 16;
	localparam int FPR_W   = 16;
	localparam int ACT_W   = 3;
	localparam int CFG_IX_W = 3;
	localparam int CFG_W   = 20;
	localparam int NUM_TIER_REGS = 6;

	// command codes
	localparam logic CMD_ADJUST = 1'b0;
	localparam logic CMD_WRITE  = 1'b1;

	// action codes
	localparam logic [ACT_W-1:0] ACT_NO_ROWS = 3'd0;
	localparam logic [ACT_W-1:0] ACT_CAP     = 3'd1;
	localparam logic [ACT_W-1:0] ACT_KEEP    = 3'd2;
	localparam logic [ACT_W-1:0] ACT_STEP    = 3'd3;
	localparam logic [ACT_W-1:0] ACT_RAISE   = 3'd4;

	// configuration register indexes
	localparam logic [CFG_IX_W-1:0] REG_THRESHOLD  = 3'd0;
	localparam logic [CFG_IX_W-1:0] REG_FRAMES     = 3'd1;
	localparam logic [CFG_IX_W-1:0] REG_TIER_FIRST = 3'd2;

	localparam logic [THR_W-1:0] THRESHOLD_RESET = 16'd52429;
	localparam logic [FPR_W-1:0] FRAMES_RESET    = 16'd1;
	localparam logic [KBPS_W-1:0] TIER_RESET [NUM_TIER_REGS] = '{
		20'd200, 20'd400, 20'd610, 20'd910, 20'd1710, 20'd3150
	};

	typedef struct packed {
		logic                command;
		logic [FRAME_W-1:0]  frame_num;
		logic [KBPS_W-1:0]   current_kbps;
		logic [KBPS_W-1:0]   cc_kbps;
		logic [ROWIX_W-1:0]  row_index;
		logic [TIERIX_W-1:0] tier_index;
		logic [CONFIN_W-1:0] conf_value;
	} cmd_t;

	typedef struct packed {
		logic [KBPS_W-1:0]  out_kbps;
		logic [ACT_W-1:0]   action;
		logic [ROWIX_W-1:0] row_used;
	} res_t;

endpackage
`default_nettype wire

// ----- hdl/cba_div.sv -----
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module cba_div #(
	parameter int NW = 36,
	parameter int DW = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	output logic               busy,
	output logic               done,
	output logic [NW-1:0]      quo,
	output logic [DW-1:0]      rem
);

	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] work_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic          run_q;
	logic          done_q;
	logic [DW:0]   trial;
	logic          ge;

	// shift in the next dividend bit and try the subtract
	assign trial = {rem_q, work_q[NW-1]};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(NW);
			end else if (run_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath, no reset
	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= num;
			rem_q  <= '0;
			den_q  <= den;
		end else if (run_q) begin
			work_q <= {work_q[NW-2:0], ge};
			rem_q  <= ge ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
		end
	end

	assign busy = run_q;
	assign done = done_q;
	assign quo  = work_q;
	assign rem  = rem_q;

endmodule
`default_nettype wire

// ----- hdl/confidence_bitrate_adjuster_top.sv -----
// Top level of the confidence bitrate adjuster: table memory and sequencer.
//
// Channels: an item on cmd is taken at a clock edge where start is high and
// busy is low. A write command stores one table entry in that cycle when its
// row and tier are in range, and gives no result. An adjust command gives
// one result on result, marked by done for exactly one cycle; the receiver
// cannot stall and must take it. Configuration is written through cfg_we /
// cfg_index / cfg_data; the user must do so only while idle, as the block
// itself does not enforce it.
// Steps from taking the item to its result (the shared divider is NW bits
// wide, NW = max(31, max(CONF_BITS,16)+20), 36 at defaults):
//   no rows loaded: the result is registered straight from the item.
//   cap to cc:      after the row division.
//   keep / step up: the row division, one memory read per tier on the single
//                   read port, then three multiply steps when interpolating.
//   raise:          as keep when the first tier meets the threshold, else as
//                   keep followed by a second pass through the shared divider.
// One item is worked on at a time; busy drops as the result goes out, so the
// next item can be taken at the edge that takes the result.
// Reset clears the loaded-row count and sets the configuration registers to
// their reset values; table contents are undefined until written.
`timescale 1ns / 1ps
`default_nettype none
module confidence_bitrate_adjuster_top
	import cba_pkg::*;
#(
	parameter int ROWS      = 1024,
	parameter int TIERS     = 6,
	parameter int CONF_BITS = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire cmd_t                cmd,
	output logic                     done,
	output res_t                     result,
	input  wire logic                cfg_we,
	input  wire logic [CFG_IX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]    cfg_data
);

	localparam int DEPTH = ROWS * TIERS;
	localparam int AW    = $clog2(DEPTH);
	localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int RLW   = $clog2(ROWS + 1);
	localparam int HW    = $clog2(TIERS + 1);
	localparam int MW    = (CONF_BITS > 16) ? CONF_BITS : 16;
	localparam int AWD   = MW + 1;
	localparam int BWD   = KBPS_W + 1;
	localparam int PW    = AWD + BWD;
	localparam int NW2   = MW + KBPS_W;
	localparam int NW    = (NW2 > FRAME_W) ? NW2 : FRAME_W;

	typedef enum logic [3:0] {
		S_IDLE, S_DWAIT, S_RD, S_SEL, S_M1, S_M2, S_M3,
		S_CMP, S_RMUL, S_RDIV, S_RWAIT
	} state_t;

	state_t state_q;

	// configuration
	logic [THR_W-1:0]  threshold_q;
	logic [FPR_W-1:0]  frames_q;
	logic [KBPS_W-1:0] tier_q [NUM_TIER_REGS];

	// item and working registers
	logic [KBPS_W-1:0]    cur_q, cc_q;
	logic [RLW-1:0]       rows_q;
	logic [RW-1:0]        row_q;
	logic [AW-1:0]        base_q;
	logic [HW-1:0]        rd_cnt_q;
	logic [CONF_BITS-1:0] conf_q [TIERS];
	logic [HW-1:0]        hi_q;
	logic                 simple_q, simple_meets_q;
	logic signed [AWD-1:0] y0_q, dy_q;
	logic signed [BWD-1:0] dx_q, cx_q;
	logic signed [PW-1:0]  prod_q;
	logic signed [PW:0]    acc_q;
	logic [KBPS_W-1:0]    lt_q;
	logic [MW-1:0]        den_q;
	logic                 desc_q;
	res_t                 res_q;
	logic                 done_q;

	// memory
	logic [CONF_BITS-1:0] mem [DEPTH];
	logic [CONF_BITS-1:0] rd_data;
	logic                 rd_en, wr_en;
	logic [AW-1:0]        rd_addr, wr_addr;

	// divider
	logic          div_start, div_busy, div_done;
	logic [NW-1:0] div_num, div_quo;
	logic [MW-1:0] div_den, div_rem;

	logic accept, adjust_go;
	logic [RLW+16:0] wr_rows;

	// evaluation logic
	logic [HW-1:0]        hi, a_idx;
	logic                 a_found;
	logic [KBPS_W-1:0]    x0, x1, t_last, t_hi, lt, ht;
	logic [MW-1:0]        y0, y1, thr_e, lc, hc;
	logic                 meets, simple, simple_meets;
	logic signed [AWD-1:0] mul_a;
	logic signed [BWD-1:0] mul_b;
	logic [FRAME_W-1:0]   quo_row;
	logic [RW-1:0]        row_clamped;
	logic [KBPS_W:0]      raise_sum;
	logic [KBPS_W-1:0]    raise_t;

	assign accept    = start && !busy;
	assign adjust_go = accept && cmd.command == CMD_ADJUST && rows_q != '0;
	assign wr_en     = accept && cmd.command == CMD_WRITE
		&& 32'(cmd.row_index) < ROWS && 32'(cmd.tier_index) < TIERS;
	assign wr_addr   = AW'(32'(cmd.row_index) * TIERS + 32'(cmd.tier_index));
	assign wr_rows   = (RLW+17)'(cmd.row_index) + (RLW+17)'(1);
	assign rd_en     = state_q == S_RD && 32'(rd_cnt_q) < TIERS;
	assign rd_addr   = base_q + AW'(rd_cnt_q);
	assign thr_e     = MW'(threshold_q);

	// table memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= CONF_BITS'(cmd.conf_value);
		if (rd_en)
			rd_data <= mem[rd_addr];
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RESET;
			frames_q    <= FRAMES_RESET;
			for (int i = 0; i < NUM_TIER_REGS; i++)
				tier_q[i] <= TIER_RESET[i];
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_THRESHOLD: threshold_q <= cfg_data[THR_W-1:0];
				REG_FRAMES:    frames_q <= cfg_data[FPR_W-1:0];
				default:       tier_q[cfg_index - REG_TIER_FIRST] <= cfg_data;
			endcase
		end
	end

	// shared divider: row selection, then inverse interpolation
	assign div_start = adjust_go || state_q == S_RDIV;
	assign div_num   = (state_q == S_RDIV) ? NW'($unsigned(prod_q)) : NW'(cmd.frame_num);
	assign div_den   = (state_q == S_RDIV) ? den_q
		: ((frames_q == '0) ? MW'(1) : MW'(frames_q));

	cba_div #(.NW(NW), .DW(MW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.done   (div_done),
		.quo    (div_quo),
		.rem    (div_rem)
	);

	// clamp the row to the loaded rows
	assign quo_row     = div_quo[FRAME_W-1:0];
	assign row_clamped = (32'(quo_row) >= 32'(rows_q)) ? RW'(rows_q - RLW'(1)) : RW'(quo_row);

	// tier scans and operand selection
	always_comb begin
		t_last = tier_q[TIERS-1];
		hi = HW'(TIERS);
		for (int i = TIERS - 1; i >= 0; i--)
			if (tier_q[i] > cur_q)
				hi = HW'(i);
		x0 = '0; x1 = '0; y0 = '0; y1 = '0; t_hi = cur_q;
		for (int i = 0; i < TIERS; i++) begin
			if (HW'(i) == hi) begin
				x1 = tier_q[i];
				y1 = MW'(conf_q[i]);
			end
			if (HW'(i + 1) == hi) begin
				x0 = tier_q[i];
				y0 = MW'(conf_q[i]);
			end
			if (HW'(i) == hi_q)
				t_hi = tier_q[i];
		end
		simple = cur_q <= tier_q[0] || cur_q >= t_last
			|| hi == HW'(TIERS) || hi == '0;
		simple_meets = (cur_q <= tier_q[0]) ? (MW'(conf_q[0]) >= thr_e)
			: (MW'(conf_q[TIERS-1]) >= thr_e);
		meets = simple_q ? simple_meets_q : (acc_q >= PW'(prod_q) + (PW+1)'(0));
		a_found = 1'b0;
		a_idx = '0;
		for (int i = TIERS - 1; i >= 0; i--)
			if (MW'(conf_q[i]) >= thr_e) begin
				a_found = 1'b1;
				a_idx = HW'(i);
			end
		lc = '0; hc = '0; lt = '0; ht = '0;
		for (int i = 0; i < TIERS; i++) begin
			if (HW'(i) == a_idx) begin
				hc = MW'(conf_q[i]);
				ht = tier_q[i];
			end
			if (HW'(i + 1) == a_idx) begin
				lc = MW'(conf_q[i]);
				lt = tier_q[i];
			end
		end
	end

	// raised rate: ceiling up a rising line, floor down a falling one
	always_comb begin
		if (desc_q)
			raise_sum = {1'b0, lt_q} - {1'b0, div_quo[KBPS_W-1:0]};
		else
			raise_sum = {1'b0, lt_q} + {1'b0, div_quo[KBPS_W-1:0]}
				+ (KBPS_W+1)'(div_rem != '0);
		raise_t = raise_sum[KBPS_W-1:0];
	end

	// one shared multiplier, operands by step
	always_comb begin
		unique case (state_q)
			S_M2: begin
				mul_a = dy_q;
				mul_b = cx_q;
			end
			S_M3: begin
				mul_a = $signed({1'b0, thr_e});
				mul_b = dx_q;
			end
			default: begin
				mul_a = y0_q;
				mul_b = dx_q;
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			rows_q   <= '0;
			done_q   <= 1'b0;
			rd_cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (wr_en && wr_rows > (RLW+17)'(rows_q))
						rows_q <= RLW'(wr_rows);
					if (accept && cmd.command == CMD_ADJUST) begin
						cur_q <= cmd.current_kbps;
						cc_q  <= cmd.cc_kbps;
						if (rows_q == '0) begin
							res_q.out_kbps <= (cmd.current_kbps < cmd.cc_kbps)
								? cmd.current_kbps : cmd.cc_kbps;
							res_q.action   <= ACT_NO_ROWS;
							res_q.row_used <= '0;
							done_q <= 1'b1;
						end else begin
							state_q <= S_DWAIT;
						end
					end
				end
				S_DWAIT: begin
					if (div_done) begin
						row_q    <= row_clamped;
						base_q   <= AW'(32'(row_clamped) * TIERS);
						rd_cnt_q <= '0;
						if (cur_q > cc_q) begin
							res_q.out_kbps <= cc_q;
							res_q.action   <= ACT_CAP;
							res_q.row_used <= ROWIX_W'(row_clamped);
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_RD;
						end
					end
				end
				S_RD: begin
					// read one tier a cycle, capture the previous read
					rd_cnt_q <= rd_cnt_q + HW'(1);
					for (int i = 0; i < TIERS; i++)
						if (HW'(i + 1) == rd_cnt_q)
							conf_q[i] <= rd_data;
					if (32'(rd_cnt_q) == TIERS)
						state_q <= S_SEL;
				end
				S_SEL: begin
					hi_q           <= hi;
					simple_q       <= simple;
					simple_meets_q <= simple_meets;
					y0_q <= $signed({1'b0, y0});
					dy_q <= $signed({1'b0, y1}) - $signed({1'b0, y0});
					dx_q <= $signed({1'b0, x1}) - $signed({1'b0, x0});
					cx_q <= $signed({1'b0, cur_q}) - $signed({1'b0, x0});
					state_q <= simple ? S_CMP : S_M1;
				end
				S_M1: begin
					prod_q  <= mul_a * mul_b;
					state_q <= S_M2;
				end
				S_M2: begin
					acc_q   <= (PW+1)'(prod_q);
					prod_q  <= mul_a * mul_b;
					state_q <= S_M3;
				end
				S_M3: begin
					acc_q   <= acc_q + (PW+1)'(prod_q);
					prod_q  <= mul_a * mul_b;
					state_q <= S_CMP;
				end
				S_CMP: begin
					res_q.row_used <= ROWIX_W'(row_q);
					if (meets) begin
						res_q.out_kbps <= cur_q;
						res_q.action   <= ACT_KEEP;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else if (!a_found) begin
						// step up to the next tier above current
						if (cur_q < t_last && hi_q != HW'(TIERS))
							res_q.out_kbps <= (cc_q < t_hi) ? cc_q : t_hi;
						else
							res_q.out_kbps <= (cc_q < cur_q) ? cc_q : cur_q;
						res_q.action <= ACT_STEP;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else if (a_idx == '0 || hc == lc) begin
						res_q.out_kbps <= (a_idx == '0)
							? ((cc_q < tier_q[0]) ? cc_q : tier_q[0])
							: ((cc_q < ht) ? cc_q : ht);
						res_q.action <= ACT_RAISE;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						y0_q   <= $signed({1'b0, thr_e - lc});
						dx_q   <= $signed({1'b0, (ht >= lt) ? ht - lt : lt - ht});
						lt_q   <= lt;
						desc_q <= ht < lt;
						den_q  <= hc - lc;
						state_q <= S_RMUL;
					end
				end
				S_RMUL: begin
					prod_q  <= mul_a * mul_b;
					state_q <= S_RDIV;
				end
				S_RDIV: begin
					state_q <= S_RWAIT;
				end
				S_RWAIT: begin
					if (div_done) begin
						res_q.out_kbps <= (cc_q < raise_t) ? cc_q : raise_t;
						res_q.action   <= ACT_RAISE;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy   = state_q != S_IDLE;
	assign done   = done_q;
	assign result = res_q;

	// a result only appears once the block is back to idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result while busy");

	// a write command gives no result
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd.command == CMD_WRITE) |=> !done) else $error("result after write");

	// the divider only runs while the sequencer waits on it
	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy |-> (state_q == S_DWAIT || state_q == S_RWAIT))
		else $error("divider running out of turn");

	// the raised rate never passes cc
	a_raise_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.action == ACT_RAISE) |-> result.out_kbps <= cc_q)
		else $error("raised rate above cc");

endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for the confidence bitrate adjuster top level.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
	import cba_pkg::*;

	localparam int N_ROWS = 1024;
	localparam int N_TIERS = 6;
	localparam int N_RANDOM = 1700;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	cmd_t cmd;
	logic done;
	res_t result;
	logic cfg_we;
	logic [CFG_IX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	confidence_bitrate_adjuster_top DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// predictor state
	logic [15:0] conf_mem [N_ROWS*N_TIERS];
	int unsigned loaded_rows;
	logic [15:0] thr_q;
	logic [15:0] fpr_q;
	logic [19:0] tier_q [N_TIERS];

	cmd_t pending_items [$];
	res_t expected_results [$];
	int errors = 0;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	// append one item to the send queue
	function automatic void add_item(cmd_t c);
		pending_items.insert(pending_items.size(), c);
	endfunction

	function automatic int first_above(logic [19:0] v);
		for (int i = 0; i < N_TIERS; i++)
			if (tier_q[i] > v)
				return i;
		return N_TIERS;
	endfunction

	// interpolated confidence at cur compared against threshold, exact
	function automatic bit meets_thr(int unsigned base, logic [19:0] cur);
		int hi;
		longint x0, x1, y0, y1, dx, lhs;
		if (cur <= tier_q[0])
			return conf_mem[base] >= thr_q;
		if (cur >= tier_q[N_TIERS-1])
			return conf_mem[base+N_TIERS-1] >= thr_q;
		hi = first_above(cur);
		if (hi <= 0 || hi >= N_TIERS)
			return conf_mem[base+N_TIERS-1] >= thr_q;
		x0 = tier_q[hi-1];
		x1 = tier_q[hi];
		y0 = conf_mem[base+hi-1];
		y1 = conf_mem[base+hi];
		dx = x1 - x0;
		lhs = y0 * dx + (longint'(cur) - x0) * (y1 - y0);
		return lhs >= longint'(thr_q) * dx;
	endfunction

	// compute the bitrate decision for one accepted item
	function automatic void predict_bitrate(cmd_t c);
		res_t r;
		int unsigned f, row, base;
		int a;
		logic [19:0] target;
		longint unsigned den, tn, num, lt, ht;
		if (c.command == CMD_WRITE) begin
			if (c.tier_index < N_TIERS) begin
				conf_mem[c.row_index*N_TIERS+c.tier_index] = c.conf_value;
				if (c.row_index + 1 > loaded_rows)
					loaded_rows = c.row_index + 1;
			end
			return;
		end
		if (loaded_rows == 0) begin
			r.out_kbps = c.current_kbps < c.cc_kbps ? c.current_kbps : c.cc_kbps;
			r.action = ACT_NO_ROWS;
			r.row_used = '0;
			expected_results.insert(expected_results.size(), r);
			return;
		end
		f = fpr_q == 0 ? 1 : fpr_q;
		row = c.frame_num / f;
		if (row >= loaded_rows)
			row = loaded_rows - 1;
		base = row * N_TIERS;
		r.row_used = row[9:0];
		if (c.current_kbps > c.cc_kbps) begin
			r.out_kbps = c.cc_kbps;
			r.action = ACT_CAP;
		end else if (meets_thr(base, c.current_kbps)) begin
			r.out_kbps = c.current_kbps;
			r.action = ACT_KEEP;
		end else begin
			a = -1;
			for (int i = 0; i < N_TIERS; i++)
				if (a < 0 && conf_mem[base+i] >= thr_q)
					a = i;
			if (a < 0) begin
				target = c.current_kbps;
				if (c.current_kbps < tier_q[N_TIERS-1] && first_above(c.current_kbps) < N_TIERS)
					target = tier_q[first_above(c.current_kbps)];
				r.action = ACT_STEP;
			end else if (a == 0) begin
				target = tier_q[0];
				r.action = ACT_RAISE;
			end else begin
				lt = tier_q[a-1];
				ht = tier_q[a];
				den = conf_mem[base+a] - conf_mem[base+a-1];
				tn = thr_q - conf_mem[base+a-1];
				if (den == 0)
					target = ht;
				else if (ht >= lt) begin
					num = tn * (ht - lt);
					target = lt + (num + den - 1) / den;
				end else begin
					num = tn * (lt - ht);
					target = lt - num / den;
				end
				r.action = ACT_RAISE;
			end
			r.out_kbps = c.cc_kbps < target ? c.cc_kbps : target;
		end
		expected_results.insert(expected_results.size(), r);
	endfunction

	// driver: present items from the queue with random gaps
	int gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 0;
			gap <= 0;
		end else if (start && !busy) begin
			predict_bitrate(cmd);
			void'(pending_items.pop_front());
			start <= 0;
			gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 80) : $urandom_range(0, 2);
		end else if (!start) begin
			if (gap > 0)
				gap <= gap - 1;
			else if (pending_items.size() > 0) begin
				cmd <= pending_items[0];
				start <= 1;
			end
		end
	end

	// monitor: compare each result with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result %p", result);
				errors++;
			end else begin
				res_t e;
				e = expected_results.pop_front();
				if (result.out_kbps !== e.out_kbps) begin
					$error("out_kbps expected %0d actual %0d", e.out_kbps, result.out_kbps);
					errors++;
				end
				if (result.action !== e.action) begin
					$error("action expected %0d actual %0d", e.action, result.action);
					errors++;
				end
				if (result.row_used !== e.row_used) begin
					$error("row_used expected %0d actual %0d", e.row_used, result.row_used);
					errors++;
				end
			end
		end
	end

	task automatic wait_drain();
		while (pending_items.size() > 0 || start || expected_results.size() > 0)
			@(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IX_W-1:0] ix, logic [CFG_W-1:0] v);
		@(posedge clk);
		cfg_we <= 1;
		cfg_index <= ix;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 0;
		if (ix == REG_THRESHOLD)
			thr_q = v[15:0];
		else if (ix == REG_FRAMES)
			fpr_q = v[15:0];
		else
			tier_q[ix - REG_TIER_FIRST] = v;
	endtask

	function automatic cmd_t make_write(int row, int tier, logic [15:0] v);
		cmd_t c;
		c = '0;
		c.command = CMD_WRITE;
		c.row_index = ROWIX_W'(row);
		c.tier_index = TIERIX_W'(tier);
		c.conf_value = v;
		c.frame_num = FRAME_W'($urandom());
		c.current_kbps = KBPS_W'($urandom());
		c.cc_kbps = KBPS_W'($urandom());
		return c;
	endfunction

	function automatic cmd_t make_adjust(logic [30:0] f, logic [19:0] cur, logic [19:0] cc);
		cmd_t c;
		c.command = CMD_ADJUST;
		c.frame_num = f;
		c.current_kbps = cur;
		c.cc_kbps = cc;
		c.row_index = ROWIX_W'($urandom());
		c.tier_index = TIERIX_W'($urandom());
		c.conf_value = CONFIN_W'($urandom());
		return c;
	endfunction

	// fill one whole row so that no unwritten entry is ever read
	task automatic load_row(int row);
		for (int t = 0; t < N_TIERS; t++)
			add_item(make_write(row, t, 16'($urandom())));
	endtask

	// frame that lands in a filled row, or in the last row of the table or past it
	function automatic logic [30:0] pick_frame(int unsigned rows_top, int unsigned f);
		if ($urandom_range(0, 1) != 0)
			return 31'($urandom_range(0, (rows_top + 1) * f - 1));
		return 31'($urandom_range(1023 * f, 32'h7FFF_FFFF));
	endfunction

	function automatic logic [19:0] rand_rate();
		case ($urandom_range(0, 3))
			0: return KBPS_W'($urandom_range(0, 4000));
			1: return KBPS_W'($urandom());
			default: return KBPS_W'(tier_q[$urandom_range(0, N_TIERS-1)]
				+ $urandom_range(0, 2) - 1);
		endcase
	endfunction

	initial begin
		int phase_items;
		int rows_hi;
		int unsigned f_eff;
		arst_n = 0;
		start = 0;
		cmd = '0;
		cfg_we = 0;
		cfg_index = '0;
		cfg_data = '0;
		loaded_rows = 0;
		thr_q = THRESHOLD_RESET;
		fpr_q = FRAMES_RESET;
		for (int i = 0; i < N_TIERS; i++)
			tier_q[i] = TIER_RESET[i];
		repeat (6) @(posedge clk);
		arst_n <= 1;

		// directed: no rows loaded, then extremes
		add_item(make_adjust('0, 20'hFFFFF, 20'd0));
		add_item(make_adjust(31'h7FFFFFFF, 20'd0, 20'hFFFFF));
		add_item(make_write(0, 6, 16'hFFFF));
		add_item(make_write(0, 7, 16'h0));
		add_item(make_adjust('0, 20'd500, 20'd600));
		add_item(make_write(0, 0, 16'h0));
		add_item(make_write(0, 1, 16'hFFFF));
		add_item(make_write(0, 2, 16'h0));
		add_item(make_write(0, 3, 16'hFFFF));
		add_item(make_write(0, 4, 16'h8000));
		add_item(make_write(0, 5, 16'hFFFF));
		add_item(make_adjust(31'h7FFFFFFF, 20'd300, 20'hFFFFF));
		add_item(make_adjust('0, 20'd150, 20'd100));
		add_item(make_adjust('0, 20'd400, 20'd400));
		add_item(make_adjust('0, 20'd0, 20'hFFFFF));
		add_item(make_adjust('0, 20'hFFFFF, 20'hFFFFF));
		add_item(make_write(1023, 0, 16'd0));
		for (int t = 1; t < N_TIERS; t++)
			add_item(make_write(1023, t, 16'd0));
		wait_drain();
		// rows 1..1022 never written; keep reads in rows 0 and 1023 only
		add_item(make_adjust(31'd1023, 20'd700, 20'hFFFFF));
		add_item(make_adjust(31'h7FFFFFFF, 20'd3150, 20'hFFFFF));
		add_item(make_adjust('0, 20'd3000, 20'hFFFFF));
		// sender holds off until every result is back
		wait_drain();

		// random phases with differing register settings; frames only reach filled rows
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin write_reg(REG_THRESHOLD, 20'd0); write_reg(REG_FRAMES, 20'd0); end
				1: begin write_reg(REG_THRESHOLD, 20'hFFFF); write_reg(REG_FRAMES, 20'hFFFF); end
				2: begin
					write_reg(REG_THRESHOLD, 20'd32768);
					write_reg(REG_FRAMES, 20'd3);
					for (int t = 0; t < N_TIERS; t++)
						write_reg(CFG_IX_W'(REG_TIER_FIRST + t),
							CFG_W'(20'hFFFFF - (N_TIERS - 1 - t) * 20'h100));
				end
				3: begin
					write_reg(REG_THRESHOLD, CFG_W'($urandom()));
					for (int t = 0; t < N_TIERS; t++)
						write_reg(CFG_IX_W'(REG_TIER_FIRST + t), CFG_W'((N_TIERS - t) * 1000));
				end
				4: begin
					write_reg(REG_FRAMES, 20'd1);
					for (int t = 0; t < N_TIERS; t++)
						write_reg(CFG_IX_W'(REG_TIER_FIRST + t),
							t == 0 ? 20'd0 : CFG_W'($urandom_range(0, 5000)));
				end
				default: begin
					write_reg(REG_THRESHOLD, 20'd52429);
					write_reg(REG_FRAMES, 20'd2);
					for (int t = 0; t < N_TIERS; t++)
						write_reg(CFG_IX_W'(REG_TIER_FIRST + t), TIER_RESET[t]);
				end
			endcase
			rows_hi = $urandom_range(1, 12);
			f_eff = (fpr_q == '0) ? 1 : int'(fpr_q);
			// fully populate rows in use; row 1023 already full
			for (int r = 0; r <= rows_hi; r++)
				load_row(r);
			phase_items = N_RANDOM / 6;
			for (int k = 0; k < phase_items; k++) begin
				if ($urandom_range(0, 7) == 0)
					add_item($urandom_range(0, 3) == 0 ?
						make_write($urandom_range(0, 1023), $urandom_range(6, 7),
							16'($urandom())) :
						make_write($urandom_range(0, rows_hi), $urandom_range(0, 5),
							16'($urandom())));
				else
					add_item(make_adjust(pick_frame(rows_hi, f_eff),
						rand_rate(), rand_rate()));
			end
			wait_drain();
		end

		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
`default_nettype wire
